// ----- rtl/b64_pkg.sv -----
// Shared types, constants and character functions of the base64 codec.
// Depends on nothing; every other file takes its names from here by scope.
`default_nettype none

package b64_pkg;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam int         GROUP_MAX   = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        t_status    status;
    } t_out_item;

    // Results of one input item, handed to the serializer as a unit.
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] data;
        logic [2:0]                count;
        logic                      last;
        t_status                   status;
    } t_group;

    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Returns {valid, sextet}; a code outside the alphabet gives sextet zero.
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b64_core.sv -----
// Input register, stream state and the per-item encode/decode logic.
// Uses b64_pkg; feeds result groups to b64_ser.
`default_nettype none

module b64_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_wdata,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire b64_pkg::t_in_item i_in_item,
    output logic             o_grp_valid,
    input  wire              i_grp_ready,
    output b64_pkg::t_group  o_grp,
    output logic             o_mode
);

    logic              r_mode;
    logic              r_in_vld;
    b64_pkg::t_in_item r_in;
    logic [23:0]       r_accum, n_accum;
    logic [1:0]        r_count, n_count;
    logic [1:0]        r_pad,   n_pad;
    logic              r_bad,   n_bad;

    b64_pkg::t_group   grp;
    logic              consume;

    logic [1:0]  gc;
    logic [2:0]  en_n;
    logic [23:0] en_acc, en_triple;
    logic [6:0]  dc;
    logic        is_pad;
    logic [5:0]  sx;
    logic [23:0] de_acc;
    logic [2:0]  nbytes;

    always_comb begin
        gc        = (r_count > 2'd2) ? 2'd0 : r_count;
        en_acc    = {r_accum[15:0], r_in.in_byte};
        en_n      = {1'b0, gc} + 3'd1;
        dc        = b64_pkg::dec_char(r_in.in_byte);
        is_pad    = (r_in.in_byte == b64_pkg::PAD_CHAR);
        sx        = is_pad ? 6'd0 : dc[5:0];
        de_acc    = {r_accum[17:0], sx};
        en_triple = en_acc;
        nbytes    = 3'd3;

        n_accum = r_accum;
        n_count = r_count;
        n_pad   = r_pad;
        n_bad   = r_bad;

        grp        = '0;
        grp.status = b64_pkg::ST_OK;

        if (r_mode == b64_pkg::MODE_ENCODE) begin
            case (en_n)
                3'd1:    en_triple = {en_acc[7:0], 16'd0};
                3'd2:    en_triple = {en_acc[15:0], 8'd0};
                default: en_triple = en_acc;
            endcase
            n_accum = en_acc;
            n_count = en_n[1:0];
            if (en_n == 3'd3 || r_in.in_last) begin
                for (int i = 0; i < b64_pkg::GROUP_MAX; i++) begin
                    if (i <= int'(en_n)) begin
                        grp.data[i] = b64_pkg::enc_char(en_triple[18-6*i +: 6]);
                    end else begin
                        grp.data[i] = b64_pkg::PAD_CHAR;
                    end
                end
                grp.count = 3'd4;
                grp.last  = r_in.in_last;
                n_accum   = '0;
                n_count   = '0;
                if (r_in.in_last) begin
                    n_pad = '0;
                    n_bad = 1'b0;
                end
            end
        end else begin
            if (is_pad) begin
                if (r_count == 2'd2) n_pad[0] = 1'b1;
                if (r_count == 2'd3) n_pad[1] = 1'b1;
            end else if (!dc[6]) begin
                n_bad = 1'b1;
            end
            n_accum = de_acc;
            if (r_count != 2'd3) begin
                n_count = r_count + 2'd1;
                if (r_in.in_last) begin
                    grp.count  = 3'd1;
                    grp.last   = 1'b1;
                    grp.status = b64_pkg::ST_BAD_LEN;
                    n_accum = '0;
                    n_count = '0;
                    n_pad   = '0;
                    n_bad   = 1'b0;
                end
            end else begin
                if (r_in.in_last) begin
                    nbytes = 3'd3 - {2'b00, n_pad[1]} - {2'b00, n_pad[0]};
                end
                grp.data[0] = de_acc[23:16];
                grp.data[1] = de_acc[15:8];
                grp.data[2] = de_acc[7:0];
                grp.count   = nbytes;
                grp.last    = r_in.in_last;
                if (r_in.in_last && n_bad) begin
                    grp.status = b64_pkg::ST_BAD_CHAR;
                end
                n_accum = '0;
                n_count = '0;
                n_pad   = '0;
                if (r_in.in_last) begin
                    n_bad = 1'b0;
                end
            end
        end
    end

    // A group with no results leaves the input register without waiting.
    assign consume     = r_in_vld && ((grp.count == 3'd0) || i_grp_ready);
    assign o_grp_valid = r_in_vld && (grp.count != 3'd0);
    assign o_grp       = grp;
    assign o_in_ready  = !r_in_vld || consume;
    assign o_mode      = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= b64_pkg::MODE_ENCODE;
            r_in_vld <= 1'b0;
            r_accum  <= '0;
            r_count  <= '0;
            r_pad    <= '0;
            r_bad    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode  <= i_cfg_wdata;
                r_accum <= '0;
                r_count <= '0;
                r_pad   <= '0;
                r_bad   <= 1'b0;
            end else if (consume) begin
                r_accum <= n_accum;
                r_count <= n_count;
                r_pad   <= n_pad;
                r_bad   <= n_bad;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_vld <= 1'b1;
            end else if (consume) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64_ser.sv -----
// Result buffer that holds one group and sends its items one per cycle while i_out_ready is high.
// Uses b64_pkg; takes groups from b64_core.
`default_nettype none

module b64_ser (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_grp_valid,
    output logic              o_grp_ready,
    input  wire b64_pkg::t_group i_grp,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output b64_pkg::t_out_item o_out_item
);

    b64_pkg::t_group r_grp;
    logic [2:0]      r_rem;
    logic [1:0]      r_idx;
    logic            fin;

    // The buffer takes a new group when empty or as its final item leaves.
    assign o_grp_ready = (r_rem == 3'd0) || ((r_rem == 3'd1) && i_out_ready);
    assign o_out_valid = (r_rem != 3'd0);
    assign fin         = (r_rem == 3'd1) && r_grp.last;

    always_comb begin
        o_out_item.out_byte = r_grp.data[r_idx];
        o_out_item.out_last = fin;
        o_out_item.status   = fin ? r_grp.status : b64_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (i_grp_valid && o_grp_ready) begin
            r_rem <= i_grp.count;
            r_idx <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_valid && o_grp_ready) begin
            r_grp <= i_grp;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/base64_codec_unit.sv -----
// Top level of the streaming base64 codec: input stage and result serializer.
// Uses b64_pkg, b64_core and b64_ser.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  result  | out       | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  config  | in        | i_cfg_we, no wait         | i_cfg_wdata (mode)
//
// An item is registered on acceptance; its results pass from the input register
// through the serializer register before they leave the result port.
// The single result port sends one item per cycle while i_out_ready is high;
// encoding emits four characters per three input bytes, decoding up to three bytes per four.
// Reset clears mode to encode and all stream state; no clearing pass is needed.
// A stalled result port holds one group in the serializer and one in the input
// register before the input side stalls.
`default_nettype none

module base64_codec_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire b64_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output b64_pkg::t_out_item o_out_item
);

    logic            grp_valid;
    logic            grp_ready;
    b64_pkg::t_group grp;
    logic            mode;

    b64_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp       (grp),
        .o_mode      (mode)
    );

    b64_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .i_grp       (grp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // An error status only ever rides on the final item of a stream.
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != b64_pkg::ST_OK) |-> o_out_item.out_last)
        else $error("error status on an item that is not the last");

    // Encoding never reports an error.
    a_encode_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && mode == b64_pkg::MODE_ENCODE) |-> o_out_item.status == b64_pkg::ST_OK)
        else $error("error status in encode mode");

    // A bad length result carries a zero byte.
    a_bad_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == b64_pkg::ST_BAD_LEN) |-> o_out_item.out_byte == 8'd0)
        else $error("bad length result with nonzero byte");

endmodule

`default_nettype wire
